// ===== rtl/core/b64le_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 line encoder package
// Shared constants, the job record passed from front to back, and the
// Base64 alphabet lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package b64le_pkg;

   localparam int BYTE_W       = 8;
   localparam int SEXTET_W     = 6;
   localparam int CHAR_W       = 7;
   localparam int LEN_W        = 8;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int POS_W        = 3;

   localparam logic [LEN_W-1:0]  LINE_LENGTH_RESET = 8'd72;
   localparam logic [CHAR_W-1:0] PAD_CHAR          = 7'h3D;
   localparam logic [CHAR_W-1:0] EOL_CHAR          = 7'h00;

   localparam logic OP_DATA  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic [3:0][SEXTET_W-1:0] sextet;    // sextet[0] is sent first
      logic                     has_chars; // four characters come before any line end
      logic [1:0]               pad_cnt;   // trailing pad characters
      logic                     eol;       // line end closes the job
   } b64le_job_type;

   function automatic logic [CHAR_W-1:0] b64_char(input logic [SEXTET_W-1:0] v);
      logic [CHAR_W-1:0] c;
      if (v < 6'd26) begin
         c = 7'h41 + {1'b0, v};
      end else if (v < 6'd52) begin
         c = 7'h61 + {1'b0, v} - 7'd26;
      end else if (v < 6'd62) begin
         c = 7'h30 + {1'b0, v} - 7'd52;
      end else if (v == 6'd62) begin
         c = 7'h2B;
      end else begin
         c = 7'h2F;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/base64_line_encoder_top.sv =====
// ----------------------------------------------------------------------------
// Base64 line encoder top level
// Raw bytes in, Base64 characters with line ends out.
// ----------------------------------------------------------------------------
// An input item is a data byte (req_tuser low) or an end-of-data flush
// (req_tuser high). Every third byte and every flush yields a burst of
// items: four characters and an optional line end, or any padded
// characters and a closing line end; rsp_tlast marks the end of each
// burst. The input side takes one item per cycle while the two-entry job
// queue has room; the output register sends one item per cycle while
// rsp_tready is high. The user must write line_length through csr_wr_en
// and csr_wr_data only while the block is idle; the block itself does not
// enforce this.
`default_nettype none

module base64_line_encoder_top (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_wr_en,
   input  wire [b64le_pkg::LEN_W-1:0]   csr_wr_data,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire [7:0]                    req_tdata,  // [7:0] data_byte
   input  wire                          req_tuser,  // op
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [7:0]                   rsp_tdata,  // [6:0] char_code, [7] zero
   output logic                         rsp_tuser,  // line_end
   output logic                         rsp_tlast   // last
);
   import b64le_pkg::*;

   b64le_job_type push_job, head_job;
   logic          push, pop, full, empty;

   b64le_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .job_push    (push),
      .job         (push_job),
      .queue_full  (full)
   );

   b64le_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty)
   );

   b64le_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .queue_empty (empty),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/core/b64le_front.sv =====
// ----------------------------------------------------------------------------
// Base64 line encoder front end
// Accepts items, collects byte groups, tracks the line count and hands
// one job per output burst to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b64le_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_wr_en,
   input  wire [b64le_pkg::LEN_W-1:0]   csr_wr_data,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire [b64le_pkg::BYTE_W-1:0]  req_tdata,
   input  wire                          req_tuser,
   output logic                         job_push,
   output b64le_pkg::b64le_job_type     job,
   input  wire                          queue_full
);
   import b64le_pkg::*;

   logic [LEN_W-1:0]  line_length_ff;
   logic [BYTE_W-1:0] held_ff [2];
   logic [1:0]        group_fill_ff, group_fill_in;
   logic [LEN_W-1:0]  line_fill_ff, line_fill_in;
   logic [LEN_W:0]    sum;
   logic              accept;
   logic [BYTE_W-1:0] a, b, c;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign a          = held_ff[0];
   assign b          = held_ff[1];
   assign c          = req_tdata;
   assign sum        = {1'b0, line_fill_ff} + 9'd4;

   always_comb begin
      group_fill_in = group_fill_ff;
      line_fill_in  = line_fill_ff;
      job_push      = 1'b0;
      job           = '0;
      if (accept) begin
         if (req_tuser == OP_DATA) begin
            if (group_fill_ff < 2'd2) begin
               group_fill_in = group_fill_ff + 2'd1;
            end else begin
               job_push      = 1'b1;
               job.sextet[0] = a[7:2];
               job.sextet[1] = {a[1:0], b[7:4]};
               job.sextet[2] = {b[3:0], c[7:6]};
               job.sextet[3] = c[5:0];
               job.has_chars = 1'b1;
               group_fill_in = 2'd0;
               if (sum >= {1'b0, line_length_ff}) begin
                  job.eol      = 1'b1;
                  line_fill_in = '0;
               end else begin
                  line_fill_in = sum[LEN_W-1:0];
               end
            end
         end else begin
            job_push = 1'b1;
            job.eol  = 1'b1;
            case (group_fill_ff)
               2'd1: begin
                  job.sextet[0] = a[7:2];
                  job.sextet[1] = {a[1:0], 4'b0000};
                  job.has_chars = 1'b1;
                  job.pad_cnt   = 2'd2;
               end
               2'd2: begin
                  job.sextet[0] = a[7:2];
                  job.sextet[1] = {a[1:0], b[7:4]};
                  job.sextet[2] = {b[3:0], 2'b00};
                  job.has_chars = 1'b1;
                  job.pad_cnt   = 2'd1;
               end
               default: begin
                  job.has_chars = 1'b0;
               end
            endcase
            group_fill_in = 2'd0;
            line_fill_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_LENGTH_RESET;
         group_fill_ff  <= 2'd0;
         line_fill_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            line_length_ff <= csr_wr_data;
         end
         group_fill_ff <= group_fill_in;
         line_fill_ff  <= line_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tuser == OP_DATA && group_fill_ff < 2'd2) begin
         held_ff[group_fill_ff[0]] <= req_tdata;
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      group_fill_ff != 2'd3)
      else $error("group fill out of range");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == OP_FLUSH) |=> (group_fill_ff == 2'd0 && line_fill_ff == '0))
      else $error("flush did not clear counts");

endmodule

`default_nettype wire

// ===== rtl/core/b64le_queue.sv =====
// ----------------------------------------------------------------------------
// Base64 line encoder job queue
// Short FIFO of jobs between the front end and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module b64le_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  wire b64le_pkg::b64le_job_type push_job,
   output logic                       full,
   input  wire                        pop,
   output b64le_pkg::b64le_job_type   head_job,
   output logic                       empty
);
   import b64le_pkg::*;

   b64le_job_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/b64le_back.sv =====
// ----------------------------------------------------------------------------
// Base64 line encoder output sequencer
// Takes jobs from the queue and sends their characters and line end as
// items, one per cycle when not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module b64le_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire b64le_pkg::b64le_job_type head_job,
   input  wire                          queue_empty,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [7:0]                   rsp_tdata,  // [6:0] char_code, [7] zero
   output logic                         rsp_tuser,  // line_end
   output logic                         rsp_tlast
);
   import b64le_pkg::*;

   b64le_job_type     job_ff;
   logic              job_valid_ff, job_valid_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic              out_eol_ff, out_eol_in;
   logic              out_last_ff, out_last_in;
   logic              out_free, emit, final_item;
   logic [POS_W-1:0]  total, n_chars;
   logic [1:0]        pos_idx;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign n_chars    = job_ff.has_chars ? 3'd4 : 3'd0;
   assign total      = n_chars + {2'b00, job_ff.eol};
   assign final_item = (pos_ff == total - 3'd1);
   assign emit       = job_valid_ff && out_free;
   assign pop        = !queue_empty && (!job_valid_ff || (emit && final_item));
   assign pos_idx    = pos_ff[1:0];

   always_comb begin
      job_valid_in = job_valid_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_eol_in   = out_eol_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_last_in  = final_item;
         if (pos_ff < n_chars) begin
            out_eol_in = 1'b0;
            if ({1'b0, pos_idx} >= 3'd4 - {1'b0, job_ff.pad_cnt}) begin
               out_char_in = PAD_CHAR;
            end else begin
               out_char_in = b64_char(job_ff.sextet[pos_idx]);
            end
         end else begin
            out_eol_in  = 1'b1;
            out_char_in = EOL_CHAR;
         end
         if (final_item) begin
            job_valid_in = 1'b0;
            pos_in       = '0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
      if (pop) begin
         job_valid_in = 1'b1;
         pos_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      out_eol_ff  <= out_eol_in;
      out_last_ff <= out_last_in;
      if (pop) begin
         job_ff <= head_job;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tuser  = out_eol_ff;
   assign rsp_tlast  = out_last_ff;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (pos_ff < total))
      else $error("sequencer position past end of job");

   a_eol_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_eol_ff) |-> (out_char_ff == EOL_CHAR && out_last_ff))
      else $error("line end item malformed");

   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      (pop && job_valid_ff) |-> (emit && final_item))
      else $error("job overwritten before it finished");

endmodule

`default_nettype wire

// ===== verif/base64_line_encoder_checker.sv =====
// ----------------------------------------------------------------------------
// Base64 line encoder checker
// Watches the register port and both item channels. Every accepted input
// item is run through a local encoder that keeps its own pending bytes,
// group count, line count and line length; the characters and line ends it
// produces are queued and each accepted output item is compared against the
// oldest one. Errors and the number of outstanding items go to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_line_encoder_checker (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_wr_en,
   input  wire [b64le_pkg::LEN_W-1:0]   csr_wr_data,
   input  wire                          req_tvalid,
   input  wire                          req_tready,
   input  wire [7:0]                    req_tdata,  // [7:0] data_byte
   input  wire                          req_tuser,  // op
   input  wire                          rsp_tvalid,
   input  wire                          rsp_tready,
   input  wire [7:0]                    rsp_tdata,  // [6:0] char_code, [7] zero
   input  wire                          rsp_tuser,  // line_end
   input  wire                          rsp_tlast,  // last
   output int                           fail_count,
   output int                           pending
);

   import b64le_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              line_end;
      logic              last;
   } b64_out_type;

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic [LEN_W-1:0] line_len   = LINE_LENGTH_RESET;
   logic [7:0]       held [2];
   logic [1:0]       group_fill = 2'd0;
   logic [7:0]       line_fill  = 8'd0;
   b64_out_type      expected_chars [$];
   int               errs       = 0;

   function automatic logic [CHAR_W-1:0] to_char(input logic [5:0] v);
      logic [7:0] c;
      c = ALPHABET[8*(63 - int'(v)) +: 8];
      return c[CHAR_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      errs++;
      $display("%0t: %s mismatch, got 0x%02h, expected 0x%02h", $time, what, got, want);
   endtask

   task automatic encode_item(input logic op, input logic [7:0] din);
      logic [CHAR_W-1:0] codes [4];
      logic [7:0]        a;
      logic [7:0]        b;
      int                n_chars;
      int                sum;
      logic              closes_line;
      b64_out_type       r;
      a           = held[0];
      b           = held[1];
      n_chars     = 0;
      closes_line = 1'b0;
      if (op == OP_DATA) begin
         if (group_fill < 2'd2) begin
            held[group_fill[0]] = din;
            group_fill = group_fill + 2'd1;
         end else begin
            codes[0]   = to_char(a[7:2]);
            codes[1]   = to_char({a[1:0], b[7:4]});
            codes[2]   = to_char({b[3:0], din[7:6]});
            codes[3]   = to_char(din[5:0]);
            n_chars    = 4;
            group_fill = 2'd0;
            sum        = int'(line_fill) + 4;
            if (sum >= int'(line_len)) begin
               closes_line = 1'b1;
               line_fill   = 8'd0;
            end else begin
               line_fill = sum[7:0];
            end
         end
      end else begin
         if (group_fill == 2'd1) begin
            codes[0] = to_char(a[7:2]);
            codes[1] = to_char({a[1:0], 4'b0000});
            codes[2] = PAD_CHAR;
            codes[3] = PAD_CHAR;
            n_chars  = 4;
         end else if (group_fill == 2'd2) begin
            codes[0] = to_char(a[7:2]);
            codes[1] = to_char({a[1:0], b[7:4]});
            codes[2] = to_char({b[3:0], 2'b00});
            codes[3] = PAD_CHAR;
            n_chars  = 4;
         end
         closes_line = 1'b1;
         group_fill  = 2'd0;
         line_fill   = 8'd0;
      end
      for (int i = 0; i < n_chars; i++) begin
         r.char_code = codes[i];
         r.line_end  = 1'b0;
         r.last      = !closes_line && (i == n_chars - 1);
         expected_chars.push_back(r);
      end
      if (closes_line) begin
         r.char_code = EOL_CHAR;
         r.line_end  = 1'b1;
         r.last      = 1'b1;
         expected_chars.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      b64_out_type want;
      if (reset) begin
         line_len   = LINE_LENGTH_RESET;
         held[0]    = 8'd0;
         held[1]    = 8'd0;
         group_fill = 2'd0;
         line_fill  = 8'd0;
         expected_chars.delete();
      end else begin
         if (csr_wr_en) begin
            line_len = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            encode_item(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata, 8'h00);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== {1'b0, want.char_code}) begin
                  report_mismatch("char_code", rsp_tdata, {1'b0, want.char_code});
               end
               if (rsp_tuser !== want.line_end) begin
                  report_mismatch("line_end", {7'd0, rsp_tuser}, {7'd0, want.line_end});
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch("last", {7'd0, rsp_tlast}, {7'd0, want.last});
               end
            end
         end
      end
      fail_count <= errs;
      pending    <= expected_chars.size();
   end

endmodule

// ===== verif/base64_line_encoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// Base64 line encoder testbench
// Drives bytes and end-of-data flushes into the encoder across a range of
// line lengths (zero, below four, not a multiple of four, the extremes and
// above the nominal range), with random gaps on input and random stalls on
// output, one long output hold-off that backs up the input, and a final
// stretch at full rate. The checker predicts and compares every item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_line_encoder_top_tb;

   import b64le_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 20;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic [LEN_W-1:0] csr_wr_data = '0;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata   = 8'd0;
   logic             req_tuser   = OP_DATA;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [7:0]       rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tlast;

   int fail_count;
   int pending;
   int quiet    = 0;
   bit idle_on  = 1'b1;
   bit hold_now = 1'b0;

   always #5 clock = ~clock;

   base64_line_encoder_top uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   base64_line_encoder_checker chk (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // output side: random stalls, one long hold-off on request
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_now) begin
            hold_now = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (stall > 0) begin
            stall--;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 16) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic op, input logic [7:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic long_message(input int n_bytes);
      repeat (n_bytes) send_item(OP_DATA, 8'($urandom_range(0, 255)));
      send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
   endtask

   // mostly complete messages; now and then no flush, so groups run on
   task automatic run_messages(input int budget, input int max_len);
      int n_bytes;
      int sent;
      sent = 0;
      while (sent < budget) begin
         n_bytes = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                               : $urandom_range(0, max_len);
         repeat (n_bytes) send_item(OP_DATA, 8'($urandom_range(0, 255)));
         sent += n_bytes;
         if ($urandom_range(0, 7) != 0) begin
            send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   // wait until the encoder has drained, then write the line length
   task automatic set_line_length(input logic [LEN_W-1:0] len);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_FLUSH, 8'h00);
      send_item(OP_DATA, 8'h00);
      send_item(OP_DATA, 8'h00);
      send_item(OP_DATA, 8'h00);
      send_item(OP_DATA, 8'hFF);
      send_item(OP_DATA, 8'hFF);
      send_item(OP_DATA, 8'hFF);
      send_item(OP_DATA, 8'hFB);
      send_item(OP_DATA, 8'hEF);
      send_item(OP_DATA, 8'hBE);
      send_item(OP_DATA, 8'h4D);
      send_item(OP_DATA, 8'h61);
      send_item(OP_DATA, 8'h6E);
      send_item(OP_DATA, 8'hFF);
      send_item(OP_FLUSH, 8'hFF);
      send_item(OP_DATA, 8'h80);
      send_item(OP_DATA, 8'h01);
      send_item(OP_FLUSH, 8'h00);
      send_item(OP_FLUSH, 8'hA5);
      run_messages(20, 20);

      set_line_length(8'd4);
      run_messages(12, 8);
      set_line_length(8'd0);
      run_messages(6, 6);
      set_line_length(8'd3);
      run_messages(6, 6);
      set_line_length(8'd10);
      run_messages(12, 12);
      set_line_length(8'd252);
      long_message(12);
      set_line_length(8'd255);
      long_message(12);

      set_line_length(8'd8);
      hold_now = 1'b1;
      long_message(24);

      set_line_length(8'd72);
      idle_on = 1'b0;
      run_messages(20, 24);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
